/* rtl/tmgr_pkg.sv */
// shared constants and types for the text mode glyph renderer
package tmgr_pkg;

	// font geometry
	localparam int GLYPH_COUNT = 256;
	localparam int GLYPH_LINES = 16;

	// fixed field widths
	localparam int KIND_W   = 2;
	localparam int WORD_W   = 16;
	localparam int POS_W    = 8;
	localparam int LINE_W   = 4;
	localparam int STORE_AW = 12;
	localparam int DATA_W   = 32;
	localparam int X_W      = 11;
	localparam int Y_W      = 12;
	localparam int COLOR_W  = 32;
	localparam int IDX_W    = 4;
	localparam int GLYPH_W  = 8;
	localparam int CODE_W   = 8;
	localparam int SUM_W    = 16;

	// pixels per glyph line and serializer counter
	localparam int CELL_W = 8;
	localparam int CNT_W  = $clog2(CELL_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CELL_W - 1);

	// palette and font stores
	localparam int STORE_DEPTH = 1 << STORE_AW;
	localparam int PAL_DEPTH   = 1 << IDX_W;

	// configuration port
	localparam int CFG_IW = 8;
	localparam int CFG_DW = 8;

	typedef enum logic [CFG_IW-1:0] {
		REG_CURSOR_COLUMN = 8'd0,
		REG_CURSOR_ROW    = 8'd1
	} reg_index_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_RENDER  = 2'd0,
		KIND_FONT    = 2'd1,
		KIND_PALETTE = 2'd2
	} kind_t;

endpackage

/* rtl/tmgr_if.sv */
// channel interfaces: request items, pixel items and register writes
interface tmgr_req_if;
	logic                             valid;
	logic                             ready;
	logic [tmgr_pkg::KIND_W-1:0]      kind;
	logic [tmgr_pkg::WORD_W-1:0]      cell_word;
	logic [tmgr_pkg::POS_W-1:0]       cell_column;
	logic [tmgr_pkg::POS_W-1:0]       cell_line;
	logic [tmgr_pkg::LINE_W-1:0]      glyph_line;
	logic [tmgr_pkg::STORE_AW-1:0]    store_index;
	logic [tmgr_pkg::DATA_W-1:0]      store_data;

	modport source (output valid, kind, cell_word, cell_column, cell_line, glyph_line,
		store_index, store_data, input ready);
	modport sink (input valid, kind, cell_word, cell_column, cell_line, glyph_line,
		store_index, store_data, output ready);
endinterface

interface tmgr_pix_if;
	logic                           valid;
	logic                           ready;
	logic [tmgr_pkg::X_W-1:0]       pixel_x;
	logic [tmgr_pkg::Y_W-1:0]       pixel_y;
	logic [tmgr_pkg::COLOR_W-1:0]   pixel_color;
	logic                           last_pixel;

	modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
	modport sink (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

interface tmgr_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [tmgr_pkg::CFG_IW-1:0]    index;
	logic [tmgr_pkg::CFG_DW-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/text_mode_glyph_renderer_core.sv */
// text mode glyph renderer: font and palette lookup with a pixel serializer
// a render item passes stage 1, stage 2 (font read), stage 3 (palette read, serializer)
// and the output register; the serializer sends one pixel per cycle when the output side
// does not stall, and takes the next render item as it sends the last pixel of the current
// one; font and palette write items pass at one per cycle unless a stalled item is ahead
// reset: arst_n clears valids, counter and cursor; font and palette hold garbage
module text_mode_glyph_renderer_core (
	input  logic        clk,
	input  logic        arst_n,
	tmgr_req_if.sink    req,
	tmgr_pix_if.source  pix,
	tmgr_cfg_if.sink    cfg
);

	// cursor registers
	logic [tmgr_pkg::POS_W-1:0] cursor_col_q;
	logic [tmgr_pkg::POS_W-1:0] cursor_row_q;

	// stage 1: accepted item
	logic                              valid_s1;
	logic [tmgr_pkg::KIND_W-1:0]       kind_s1;
	logic [tmgr_pkg::WORD_W-1:0]       word_s1;
	logic [tmgr_pkg::POS_W-1:0]        col_s1;
	logic [tmgr_pkg::POS_W-1:0]        row_s1;
	logic [tmgr_pkg::LINE_W-1:0]       gl_s1;
	logic [tmgr_pkg::STORE_AW-1:0]     sidx_s1;
	logic [tmgr_pkg::DATA_W-1:0]       sdat_s1;

	// stage 2: glyph byte and color indices
	logic                              valid_s2;
	logic [tmgr_pkg::KIND_W-1:0]       kind_s2;
	logic [tmgr_pkg::IDX_W-1:0]        fg_s2;
	logic [tmgr_pkg::IDX_W-1:0]        bg_s2;
	logic [tmgr_pkg::POS_W-1:0]        col_s2;
	logic [tmgr_pkg::Y_W-1:0]          y_s2;
	logic [tmgr_pkg::GLYPH_W-1:0]      glyph_s2;

	// stage 3: serializer
	logic                              valid_s3;
	logic [tmgr_pkg::CNT_W-1:0]        cnt_s3;
	logic [tmgr_pkg::GLYPH_W-1:0]      glyph_s3;
	logic [tmgr_pkg::COLOR_W-1:0]      fg_color_s3;
	logic [tmgr_pkg::COLOR_W-1:0]      bg_color_s3;
	logic [tmgr_pkg::POS_W-1:0]        col_s3;
	logic [tmgr_pkg::Y_W-1:0]          y_s3;

	// stage 4: output register
	logic                              valid_s4;
	logic [tmgr_pkg::X_W-1:0]          x_s4;
	logic [tmgr_pkg::Y_W-1:0]          y_s4;
	logic [tmgr_pkg::COLOR_W-1:0]      color_s4;
	logic                              last_s4;

	// stores
	logic [tmgr_pkg::GLYPH_W-1:0]      font_mem [tmgr_pkg::STORE_DEPTH];
	logic [tmgr_pkg::COLOR_W-1:0]      pal_mem  [tmgr_pkg::PAL_DEPTH];

	// flow control
	logic out_load;
	logic emit;
	logic s3_take;
	logic adv2;
	logic s2_free;
	logic adv1;
	logic in_acc;

	// stage 1 datapath
	logic [tmgr_pkg::CODE_W-1:0]   code_red;
	logic [tmgr_pkg::LINE_W-1:0]   line_red;
	logic [tmgr_pkg::SUM_W-1:0]    addr_sum;
	logic [tmgr_pkg::SUM_W-1:0]    y_sum;
	logic [tmgr_pkg::STORE_AW-1:0] font_addr;
	logic                          at_cursor;
	logic                          font_we;
	logic                          pal_we;
	logic                          pix_bit;

	// handshake and stall chain, output side first
	assign out_load = !valid_s4 || pix.ready;
	assign emit     = valid_s3 && out_load;
	assign s3_take  = !valid_s3 || (emit && cnt_s3 == tmgr_pkg::CNT_LAST);
	assign adv2     = valid_s2 && (kind_s2 != tmgr_pkg::KIND_RENDER || s3_take);
	assign s2_free  = !valid_s2 || adv2;
	assign adv1     = valid_s1 && s2_free;
	assign req.ready = !valid_s1 || s2_free;
	assign in_acc   = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_col_q <= '0;
			cursor_row_q <= '0;
		end else if (cfg.valid) begin
			if (cfg.index == tmgr_pkg::REG_CURSOR_COLUMN) begin
				cursor_col_q <= cfg.data[tmgr_pkg::POS_W-1:0];
			end else if (cfg.index == tmgr_pkg::REG_CURSOR_ROW) begin
				cursor_row_q <= cfg.data[tmgr_pkg::POS_W-1:0];
			end
		end
	end

	// valid bits and serializer count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			cnt_s3   <= '0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (s3_take) begin
				valid_s3 <= adv2 && kind_s2 == tmgr_pkg::KIND_RENDER;
				cnt_s3   <= '0;
			end else if (emit) begin
				cnt_s3 <= cnt_s3 + 1'b1;
			end
			if (out_load) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	// stage 1 capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_s1 <= req.kind;
			word_s1 <= req.cell_word;
			col_s1  <= req.cell_column;
			row_s1  <= req.cell_line;
			gl_s1   <= req.glyph_line;
			sidx_s1 <= req.store_index;
			sdat_s1 <= req.store_data;
		end
	end

	// code and line reduction, font address, pixel row, cursor match
	always_comb begin
		code_red = word_s1[tmgr_pkg::CODE_W-1:0];
		if (32'(code_red) >= tmgr_pkg::GLYPH_COUNT) begin
			code_red = code_red - tmgr_pkg::CODE_W'(tmgr_pkg::GLYPH_COUNT);
		end
		line_red = gl_s1;
		if (32'(line_red) >= tmgr_pkg::GLYPH_LINES) begin
			line_red = line_red - tmgr_pkg::LINE_W'(tmgr_pkg::GLYPH_LINES);
		end
		addr_sum = tmgr_pkg::SUM_W'(code_red) * tmgr_pkg::SUM_W'(tmgr_pkg::GLYPH_LINES)
			+ tmgr_pkg::SUM_W'(line_red);
		y_sum = tmgr_pkg::SUM_W'(row_s1) * tmgr_pkg::SUM_W'(tmgr_pkg::GLYPH_LINES)
			+ tmgr_pkg::SUM_W'(line_red);
		font_addr = (kind_s1 == tmgr_pkg::KIND_FONT) ? sidx_s1
			: addr_sum[tmgr_pkg::STORE_AW-1:0];
		at_cursor = col_s1 == cursor_col_q && row_s1 == cursor_row_q;
		font_we   = adv1 && kind_s1 == tmgr_pkg::KIND_FONT;
		pal_we    = adv1 && kind_s1 == tmgr_pkg::KIND_PALETTE;
	end

	// font store: one port, write or registered read
	always_ff @(posedge clk) begin
		if (font_we) begin
			font_mem[font_addr] <= sdat_s1[tmgr_pkg::GLYPH_W-1:0];
		end else if (adv1) begin
			glyph_s2 <= font_mem[font_addr];
		end
	end

	// stage 2 capture
	always_ff @(posedge clk) begin
		if (adv1) begin
			kind_s2 <= kind_s1;
			col_s2  <= col_s1;
			y_s2    <= y_sum[tmgr_pkg::Y_W-1:0];
			if (at_cursor) begin
				fg_s2 <= word_s1[11:8];
				bg_s2 <= word_s1[15:12];
			end else begin
				fg_s2 <= word_s1[15:12];
				bg_s2 <= word_s1[11:8];
			end
		end
	end

	// palette: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (pal_we) begin
			pal_mem[sidx_s1[tmgr_pkg::IDX_W-1:0]] <= sdat_s1;
		end
		if (adv2 && s3_take) begin
			fg_color_s3 <= pal_mem[fg_s2];
			bg_color_s3 <= pal_mem[bg_s2];
		end
	end

	// stage 3 capture
	always_ff @(posedge clk) begin
		if (adv2 && s3_take) begin
			glyph_s3 <= glyph_s2;
			col_s3   <= col_s2;
			y_s3     <= y_s2;
		end
	end

	// pick glyph bit, most significant first
	assign pix_bit = glyph_s3[tmgr_pkg::CNT_LAST - cnt_s3];

	// output register
	always_ff @(posedge clk) begin
		if (emit) begin
			x_s4     <= {col_s3, cnt_s3};
			y_s4     <= y_s3;
			color_s4 <= pix_bit ? fg_color_s3 : bg_color_s3;
			last_s4  <= cnt_s3 == tmgr_pkg::CNT_LAST;
		end
	end

	assign pix.valid       = valid_s4;
	assign pix.pixel_x     = x_s4;
	assign pix.pixel_y     = y_s4;
	assign pix.pixel_color = color_s4;
	assign pix.last_pixel  = last_s4;

	// a pixel taken before the last one leaves its item in the serializer
	a_serializer_holds: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid && pix.ready && !pix.last_pixel |-> valid_s3)
		else $error("serializer empty before last pixel");

	// last pixel of a line goes out right after the final count
	a_last_marked: assert property (@(posedge clk) disable iff (!arst_n)
		emit && cnt_s3 == tmgr_pkg::CNT_LAST |=> pix.valid && pix.last_pixel)
		else $error("last pixel not marked");

	// a running count means the serializer held an item the cycle before
	a_count_runs: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && cnt_s3 != '0 |-> $past(valid_s3))
		else $error("serializer count without item");

endmodule
